// File: sv/vntc_pkg.sv
package vntc_pkg;

    localparam int unsigned COORD_BITS = 12;

    // Input item: one tile coordinate pair.
    typedef struct packed {
        logic [COORD_BITS-1:0] tile_x;
        logic [COORD_BITS-1:0] tile_y;
    } t_tile_in;

    typedef enum logic [1:0] {
        KIND_WATER  = 2'd0,
        KIND_FOREST = 2'd1,
        KIND_ROAD   = 2'd2,
        KIND_GRASS  = 2'd3
    } t_tile_kind;

    // Result item.
    typedef struct packed {
        t_tile_kind  tile_kind;
        logic        walkable;
        logic [15:0] noise_level;
    } t_tile_out;

    // Corner values and faded fractions handed from the lattice to the blend pipeline.
    typedef struct packed {
        logic [15:0] v00;
        logic [15:0] v10;
        logic [15:0] v01;
        logic [15:0] v11;
        logic [15:0] fade_u;
        logic [15:0] fade_v;
    } t_corners;

    // Register contents seen by the datapath.
    typedef struct packed {
        logic [31:0] seed_mix;
        logic [15:0] water_level;
        logic [15:0] forest_level;
        logic [15:0] road_level;
    } t_cfg_regs;

    localparam int unsigned ADDR_BITS = 4;

    localparam logic [1:0] REG_NOISE_SEED   = 2'd0;
    localparam logic [1:0] REG_WATER_LEVEL  = 2'd1;
    localparam logic [1:0] REG_FOREST_LEVEL = 2'd2;
    localparam logic [1:0] REG_ROAD_LEVEL   = 2'd3;

    localparam logic [31:0] RST_NOISE_SEED   = 32'd1;
    localparam logic [15:0] RST_WATER_LEVEL  = 16'd19661;
    localparam logic [15:0] RST_FOREST_LEVEL = 16'd39322;
    localparam logic [15:0] RST_ROAD_LEVEL   = 16'd45875;

    localparam logic [31:0] HASH_X    = 32'd143087104;
    localparam logic [31:0] HASH_Y    = 32'd104781098;
    localparam logic [31:0] HASH_XY   = 32'd247868202;
    localparam logic [31:0] HASH_SEED = 32'd969588582;
    localparam logic [31:0] HASH_MIX  = 32'd5434818;
    localparam logic [31:0] RST_SEED_MIX = 32'd969588582;

    // x / 10 == (x * 52429) >> 19 for every x below 81920.
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int unsigned DIV10_SHIFT = 19;

    localparam int unsigned LATTICE_STEP = 10;

    // Quintic fade of the fraction that belongs to a coordinate residue.
    function automatic logic [15:0] fade_of(input int unsigned r);
        longint t;
        longint t2;
        longint t3;
        longint q;
        longint f;
        t  = (longint'(r) * 65536) / 10;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        q  = 6 * t2 - 15 * t + 655360;
        f  = (t3 * q) >>> 16;
        if (f > 65535) begin
            f = 65535;
        end
        return 16'(f);
    endfunction

    localparam logic [15:0] FADE_LUT [LATTICE_STEP] = '{
        fade_of(0), fade_of(1), fade_of(2), fade_of(3), fade_of(4),
        fade_of(5), fade_of(6), fade_of(7), fade_of(8), fade_of(9)
    };

endpackage

// File: sv/vntc_cfg.sv
module vntc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vntc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output vntc_pkg::t_cfg_regs            o_cfg
);

    logic [31:0] r_noise_seed;
    logic [31:0] r_seed_mix;
    logic [15:0] r_water_level;
    logic [15:0] r_forest_level;
    logic [15:0] r_road_level;
    logic        w_write;
    logic [1:0]  w_index;

    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[3:2];
    assign pready  = 1'b1;

    // The seed product is formed when the seed is written, so the hash path
    // only adds it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_seed   <= vntc_pkg::RST_NOISE_SEED;
            r_seed_mix     <= vntc_pkg::RST_SEED_MIX;
            r_water_level  <= vntc_pkg::RST_WATER_LEVEL;
            r_forest_level <= vntc_pkg::RST_FOREST_LEVEL;
            r_road_level   <= vntc_pkg::RST_ROAD_LEVEL;
        end else if (w_write) begin
            unique case (w_index)
                vntc_pkg::REG_NOISE_SEED: begin
                    r_noise_seed <= pwdata;
                    r_seed_mix   <= pwdata * vntc_pkg::HASH_SEED;
                end
                vntc_pkg::REG_WATER_LEVEL:  r_water_level  <= pwdata[15:0];
                vntc_pkg::REG_FOREST_LEVEL: r_forest_level <= pwdata[15:0];
                vntc_pkg::REG_ROAD_LEVEL:   r_road_level   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            vntc_pkg::REG_NOISE_SEED:   prdata = r_noise_seed;
            vntc_pkg::REG_WATER_LEVEL:  prdata = {16'd0, r_water_level};
            vntc_pkg::REG_FOREST_LEVEL: prdata = {16'd0, r_forest_level};
            vntc_pkg::REG_ROAD_LEVEL:   prdata = {16'd0, r_road_level};
            default:                    prdata = 32'd0;
        endcase
    end

    assign o_cfg.seed_mix     = r_seed_mix;
    assign o_cfg.water_level  = r_water_level;
    assign o_cfg.forest_level = r_forest_level;
    assign o_cfg.road_level   = r_road_level;

endmodule

// File: sv/vntc_lattice.sv
module vntc_lattice (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vntc_pkg::t_tile_in i_in_data,
    input  logic [31:0]        i_seed_mix,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vntc_pkg::t_corners o_out_data
);

    localparam int unsigned COORD_BITS = vntc_pkg::COORD_BITS;
    localparam int unsigned CELL_BITS  = COORD_BITS - 3;
    localparam int unsigned PW         = COORD_BITS + 16;
    localparam int unsigned STAGES     = 5;

    function automatic logic [15:0] corner_value(input logic [31:0] n);
        logic [31:0] m;
        logic [31:0] h;
        m = n ^ {{13{n[31]}}, n[31:13]};
        h = m * vntc_pkg::HASH_MIX;
        return h[30:15];
    endfunction

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] w_en;

    // Stage 1: cell index by reciprocal multiply.
    logic [COORD_BITS-1:0] w_x;
    logic [COORD_BITS-1:0] w_y;
    logic [PW-1:0]         w_qx;
    logic [PW-1:0]         w_qy;
    logic [COORD_BITS-1:0] r1_x;
    logic [COORD_BITS-1:0] r1_y;
    logic [CELL_BITS-1:0]  r1_cx;
    logic [CELL_BITS-1:0]  r1_cy;

    // Stage 2: fade lookup and the two coordinate hash products.
    logic [COORD_BITS-1:0] w_rx_full;
    logic [COORD_BITS-1:0] w_ry_full;
    logic [3:0]            w_rx;
    logic [3:0]            w_ry;
    logic [15:0]           r2_u;
    logic [15:0]           r2_v;
    logic [31:0]           r2_pa;
    logic [31:0]           r2_pb;

    // Stage 3: hash input of the lower-left corner.
    logic [15:0] r3_u;
    logic [15:0] r3_v;
    logic [31:0] r3_n;

    // Stage 4: hash inputs of all four corners.
    logic [15:0] r4_u;
    logic [15:0] r4_v;
    logic [31:0] r4_n00;
    logic [31:0] r4_n10;
    logic [31:0] r4_n01;
    logic [31:0] r4_n11;

    // Stage 5: corner values.
    vntc_pkg::t_corners r5_data;

    always_comb begin
        w_en[STAGES-1] = !r_v[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_in_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign w_x  = COORD_BITS'(i_in_data.tile_x);
    assign w_y  = COORD_BITS'(i_in_data.tile_y);
    assign w_qx = PW'(w_x) * PW'(vntc_pkg::DIV10_MUL);
    assign w_qy = PW'(w_y) * PW'(vntc_pkg::DIV10_MUL);

    assign w_rx_full = r1_x - ((COORD_BITS'(r1_cx) << 3) + (COORD_BITS'(r1_cx) << 1));
    assign w_ry_full = r1_y - ((COORD_BITS'(r1_cy) << 3) + (COORD_BITS'(r1_cy) << 1));
    assign w_rx      = w_rx_full[3:0];
    assign w_ry      = w_ry_full[3:0];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_x  <= w_x;
            r1_y  <= w_y;
            r1_cx <= w_qx[PW-1:vntc_pkg::DIV10_SHIFT];
            r1_cy <= w_qy[PW-1:vntc_pkg::DIV10_SHIFT];
        end
        if (w_en[1]) begin
            r2_u  <= vntc_pkg::FADE_LUT[w_rx];
            r2_v  <= vntc_pkg::FADE_LUT[w_ry];
            r2_pa <= 32'(r1_cx) * vntc_pkg::HASH_X;
            r2_pb <= 32'(r1_cy) * vntc_pkg::HASH_Y;
        end
        if (w_en[2]) begin
            r3_u <= r2_u;
            r3_v <= r2_v;
            r3_n <= r2_pa + r2_pb + i_seed_mix;
        end
        if (w_en[3]) begin
            // Stepping a cell index by one adds its hash constant, modulo 2^32.
            r4_u   <= r3_u;
            r4_v   <= r3_v;
            r4_n00 <= r3_n;
            r4_n10 <= r3_n + vntc_pkg::HASH_X;
            r4_n01 <= r3_n + vntc_pkg::HASH_Y;
            r4_n11 <= r3_n + vntc_pkg::HASH_XY;
        end
        if (w_en[4]) begin
            r5_data.v00    <= corner_value(r4_n00);
            r5_data.v10    <= corner_value(r4_n10);
            r5_data.v01    <= corner_value(r4_n01);
            r5_data.v11    <= corner_value(r4_n11);
            r5_data.fade_u <= r4_u;
            r5_data.fade_v <= r4_v;
        end
    end

    assign o_out_valid = r_v[STAGES-1];
    assign o_out_data  = r5_data;

    a_stall_holds_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] && !w_en[2] |=> r_v[2] && $stable(r3_n))
        else $error("lattice stage lost or changed a stalled item");

    a_ready_low_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_v) && !i_out_ready)
        else $error("lattice refused input while a stage was free");

endmodule

// File: sv/vntc_blend.sv
module vntc_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vntc_pkg::t_corners  i_in_data,
    input  vntc_pkg::t_cfg_regs i_cfg,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vntc_pkg::t_tile_out o_out_data
);

    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] w_en;

    // Stage 1: horizontal lerp products for both rows.
    logic        r1_ge0;
    logic        r1_ge1;
    logic [15:0] r1_a0;
    logic [15:0] r1_a1;
    logic [31:0] r1_p0;
    logic [31:0] r1_p1;
    logic [15:0] r1_fv;
    logic [15:0] w_d0;
    logic [15:0] w_d1;

    // Stage 2: row results.
    logic [15:0] r2_r0;
    logic [15:0] r2_r1;
    logic [15:0] r2_fv;

    // Stage 3: vertical lerp product.
    logic        r3_ge;
    logic [15:0] r3_a;
    logic [31:0] r3_p;

    // Stage 4: level; stage 5: class.
    logic [15:0]         r4_level;
    vntc_pkg::t_tile_out r5_data;
    vntc_pkg::t_tile_kind w_kind;

    always_comb begin
        w_en[STAGES-1] = !r_v[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_in_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // The lerp works on the magnitude of the difference, so the truncated
    // step always moves toward the far corner.
    assign w_d0 = (i_in_data.v10 >= i_in_data.v00) ? i_in_data.v10 - i_in_data.v00
                                                   : i_in_data.v00 - i_in_data.v10;
    assign w_d1 = (i_in_data.v11 >= i_in_data.v01) ? i_in_data.v11 - i_in_data.v01
                                                   : i_in_data.v01 - i_in_data.v11;

    always_comb begin
        priority if (r4_level < i_cfg.water_level) begin
            w_kind = vntc_pkg::KIND_WATER;
        end else if (r4_level < i_cfg.forest_level) begin
            w_kind = vntc_pkg::KIND_FOREST;
        end else if (r4_level < i_cfg.road_level) begin
            w_kind = vntc_pkg::KIND_ROAD;
        end else begin
            w_kind = vntc_pkg::KIND_GRASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_ge0 <= i_in_data.v10 >= i_in_data.v00;
            r1_ge1 <= i_in_data.v11 >= i_in_data.v01;
            r1_a0  <= i_in_data.v00;
            r1_a1  <= i_in_data.v01;
            r1_p0  <= 32'(i_in_data.fade_u) * 32'(w_d0);
            r1_p1  <= 32'(i_in_data.fade_u) * 32'(w_d1);
            r1_fv  <= i_in_data.fade_v;
        end
        if (w_en[1]) begin
            r2_r0 <= r1_ge0 ? r1_a0 + r1_p0[31:16] : r1_a0 - r1_p0[31:16];
            r2_r1 <= r1_ge1 ? r1_a1 + r1_p1[31:16] : r1_a1 - r1_p1[31:16];
            r2_fv <= r1_fv;
        end
        if (w_en[2]) begin
            r3_ge <= r2_r1 >= r2_r0;
            r3_a  <= r2_r0;
            r3_p  <= 32'(r2_fv) * ((r2_r1 >= r2_r0) ? 32'(r2_r1 - r2_r0)
                                                     : 32'(r2_r0 - r2_r1));
        end
        if (w_en[3]) begin
            r4_level <= r3_ge ? r3_a + r3_p[31:16] : r3_a - r3_p[31:16];
        end
        if (w_en[4]) begin
            r5_data.tile_kind   <= w_kind;
            r5_data.walkable    <= (w_kind != vntc_pkg::KIND_WATER);
            r5_data.noise_level <= r4_level;
        end
    end

    assign o_out_valid = r_v[STAGES-1];
    assign o_out_data  = r5_data;

    a_no_output_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("blend shows a result right after reset");

    a_stall_holds_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && !w_en[3] |=> r_v[3] && $stable(r4_level))
        else $error("blend level stage lost or changed a stalled item");

endmodule

// File: sv/value_noise_tile_classifier.sv
// Channel   Direction  Handshake                      Payload
// tile in   input      i_in_valid / o_in_ready        i_in_data  (vntc_pkg::t_tile_in)
// tile out  output     o_out_valid / i_out_ready      o_out_data (vntc_pkg::t_tile_out)
// config    input      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One tile enters per cycle while i_out_ready is high; each result passes through the
// lattice hash pipeline and then the blend pipeline. Throughput is one tile per cycle
// while the output is not stalled, set by the per-stage hand-off of both pipelines.
// Reset is synchronous and active low; it empties both pipelines and loads the
// register defaults. A stalled output holds every stage that has no free slot
// downstream, while empty stages keep filling, so nothing is dropped or repeated.
module value_noise_tile_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  vntc_pkg::t_tile_in             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output vntc_pkg::t_tile_out            o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vntc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    vntc_pkg::t_cfg_regs w_cfg;
    vntc_pkg::t_corners  w_corners;
    logic                w_lat_valid;
    logic                w_lat_ready;

    vntc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    vntc_lattice u_lattice (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_seed_mix  (w_cfg.seed_mix),
        .o_out_valid (w_lat_valid),
        .i_out_ready (w_lat_ready),
        .o_out_data  (w_corners)
    );

    vntc_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_lat_valid),
        .o_in_ready  (w_lat_ready),
        .i_in_data   (w_corners),
        .i_cfg       (w_cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
